// ===== sv/ili_pkg.sv =====
// Shared types and constants for the indexed list block.
// Used by the controller, the datapath and the top level; depends on nothing.
package ili_pkg;

	localparam int CNT_W  = 7;
	localparam int POS_W  = 6;
	localparam int WORD_W = 32;
	localparam int KIND_W = 3;
	localparam int ST_W   = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] REQ_READ   = 3'd2;
	localparam logic [KIND_W-1:0] REQ_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] REQ_WRITE  = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SHIFT,
		S_DRAIN,
		S_PLACE,
		S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_APPEND,
		WR_POS
	} wsel_t;

	typedef struct packed {
		logic  load_req;
		logic  rd_pos;
		logic  ptr_init;
		logic  shift_rd;
		wsel_t wr_sel;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic              no_moves;
		logic              last;
		logic              out_free;
	} stat_t;

endpackage

// ===== sv/ili_datapath.sv =====
// Datapath of the indexed list: request registers, count, capacity, entry memory,
// shift pipeline and result register. Depends on ili_pkg; driven by ili_ctrl commands.
module ili_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ili_pkg::KIND_W-1:0] req_type,
	input  logic [ili_pkg::POS_W-1:0]  position,
	input  logic [ili_pkg::WORD_W-1:0] value,
	input  logic                      cfg_valid,
	input  logic [ili_pkg::CNT_W-1:0]  cfg_data,
	input  ili_pkg::cmd_t             cmd,
	output ili_pkg::stat_t            stat,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [ili_pkg::WORD_W-1:0] read_value,
	output logic [ili_pkg::ST_W-1:0]   status,
	output logic [ili_pkg::CNT_W-1:0]  length,
	output logic                      is_empty,
	output logic                      is_full
);
	import ili_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  limit;
	logic [CNT_W-1:0]  pos_ext;
	logic [CNT_W-1:0]  count_m1;
	logic [CNT_W-1:0]  next_count;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  ptr_start;
	logic [CNT_W-1:0]  wptr_s1;
	logic              wv_s1;
	logic              full;
	logic              is_ins;
	logic              is_del;
	logic              ok;
	logic [ST_W-1:0]   st;
	logic [WORD_W-1:0] rd_word;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [CNT_W-1:0]  wr_idx;
	logic [CNT_W-1:0]  rd_idx;
	logic [WORD_W-1:0] wr_data;

	logic              out_valid_q;
	logic [WORD_W-1:0] read_value_q;
	logic [ST_W-1:0]   status_q;
	logic [CNT_W-1:0]  length_q;
	logic              is_empty_q;
	logic              is_full_q;

	// A capacity above DEPTH is capped at DEPTH.
	assign limit    = (int'(cap_q) > DEPTH) ? CNT_W'(DEPTH) : cap_q;
	assign pos_ext  = CNT_W'(pos_q);
	assign count_m1 = count_q - CNT_W'(1);
	assign full     = (count_q >= limit);
	assign is_ins   = (kind_q == REQ_INSERT);
	assign is_del   = (kind_q == REQ_DELETE);

	always_comb begin
		st = ST_DONE;
		case (kind_q)
			REQ_APPEND: begin
				if (full) st = ST_FULL;
			end
			REQ_INSERT: begin
				if (pos_ext > count_q) st = ST_BADPOS;
				else if (full) st = ST_FULL;
			end
			REQ_READ, REQ_DELETE, REQ_WRITE: begin
				if (pos_ext >= count_q) st = ST_BADPOS;
			end
			default: st = ST_DONE;
		endcase
	end

	assign ok = (st == ST_DONE);

	always_comb begin
		next_count = count_q;
		if (ok && (kind_q == REQ_APPEND || is_ins)) next_count = count_q + CNT_W'(1);
		else if (ok && is_del) next_count = count_m1;
	end

	always_comb begin
		rd_word = '0;
		if (kind_q == REQ_READ) rd_word = ok ? rdata_q : '1;
	end

	// Insert walks down from the top entry to the position, delete walks up from
	// the entry above the position; each read entry is written one place over.
	assign ptr_start = is_ins ? count_m1 : pos_ext + CNT_W'(1);

	assign stat.kind     = kind_q;
	assign stat.ok       = ok;
	assign stat.no_moves = is_ins ? (pos_ext == count_q) : (pos_ext == count_m1);
	assign stat.last     = is_ins ? (ptr_q == pos_ext) : (ptr_q == count_m1);
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		mem_we  = 1'b0;
		wr_idx  = count_q;
		wr_data = word_q;
		if (wv_s1) begin
			mem_we  = 1'b1;
			wr_idx  = is_ins ? wptr_s1 + CNT_W'(1) : wptr_s1 - CNT_W'(1);
			wr_data = rdata_q;
		end else begin
			case (cmd.wr_sel)
				WR_APPEND: begin
					mem_we = 1'b1;
					wr_idx = count_q;
				end
				WR_POS: begin
					mem_we = 1'b1;
					wr_idx = pos_ext;
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	assign mem_re = cmd.shift_rd || cmd.rd_pos;
	assign rd_idx = cmd.shift_rd ? ptr_q : pos_ext;

	always_ff @(posedge clk) begin
		if (mem_we) mem[AW'(wr_idx)] <= wr_data;
		if (mem_re) rdata_q <= mem[AW'(rd_idx)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= req_type;
			pos_q  <= position;
			word_q <= value;
		end
		if (cmd.ptr_init) ptr_q <= ptr_start;
		else if (cmd.shift_rd) ptr_q <= is_ins ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
		wptr_s1 <= ptr_q;
		if (cmd.out_load) begin
			read_value_q <= rd_word;
			status_q     <= st;
			length_q     <= next_count;
			is_empty_q   <= (next_count == '0);
			is_full_q    <= (next_count >= limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) count_q <= next_count;
			if (cfg_valid) cap_q <= cfg_data;
			wv_s1 <= cmd.shift_rd;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = length_q;
	assign is_empty   = is_empty_q;
	assign is_full    = is_full_q;

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wv_s1 && cmd.wr_sel != WR_NONE))
		else $error("shift write and command write in the same cycle");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.out_load |=> $stable(count_q))
		else $error("count changed without a result being loaded");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_rd |-> (ptr_q < count_q))
		else $error("shift read outside the list");

	a_result_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

// ===== sv/ili_ctrl.sv =====
// Controller of the indexed list: sequences evaluate, shift, place and result steps.
// Depends on ili_pkg; commands the ili_datapath and reads its status.
module ili_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ili_pkg::stat_t stat,
	output ili_pkg::cmd_t  cmd
);
	import ili_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.wr_sel   = WR_NONE;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
				if (in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_RESULT;
				if (stat.ok) begin
					case (stat.kind)
						REQ_APPEND: cmd.wr_sel = WR_APPEND;
						REQ_WRITE:  cmd.wr_sel = WR_POS;
						REQ_READ:   cmd.rd_pos = 1'b1;
						REQ_INSERT: begin
							if (stat.no_moves) begin
								cmd.wr_sel = WR_POS;
							end else begin
								cmd.ptr_init = 1'b1;
								state_d      = S_SHIFT;
							end
						end
						REQ_DELETE: begin
							if (!stat.no_moves) begin
								cmd.ptr_init = 1'b1;
								state_d      = S_SHIFT;
							end
						end
						default: state_d = S_RESULT;
					endcase
				end
			end
			S_SHIFT: begin
				cmd.shift_rd = 1'b1;
				if (stat.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// The last moved entry is written by the datapath in this cycle.
				state_d = (stat.kind == REQ_INSERT) ? S_PLACE : S_RESULT;
			end
			S_PLACE: begin
				cmd.wr_sel = WR_POS;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_shift_has_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && cmd.ptr_init) |-> (stat.ok && !stat.no_moves))
		else $error("shift started with nothing to move");

	a_place_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> (stat.kind == REQ_INSERT && stat.ok))
		else $error("placement step outside a valid insert");

	a_load_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after a result");

endmodule

// ===== sv/indexed_list_insert_delete.sv =====
// Indexed list with append, insert, read, delete and overwrite at a position.
// Channels: s_axis carries one request per item, m_axis returns exactly one
// result per request, cfg writes the capacity register (always ready, write
// it only while the block is idle).
// Append, read, overwrite, unused kinds and refused requests go from
// the evaluate step straight to the result step; a delete that moves entries
// first passes through the shift and drain steps, and an insert that moves
// entries through shift, drain and place (a delete of the last entry and an
// insert at the list end move none). The list sits in a memory with one read
// and one write port, so entries move one per cycle through the read-then-write
// pipeline; s_axis_tready returns in the cycle after the result is loaded.
// A new request is accepted while the previous result still waits on m_axis;
// if the receiver stalls, the block finishes that request and holds it until
// the result register frees up.
// Reset clears the count to zero and sets the capacity to 64; entries are not
// cleared, as only positions below the count are ever read.
module indexed_list_insert_delete #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position[5:0], value[37:6], zero pad
	input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // read_value[31:0], length[38:32],
	                                   // is_empty[39], is_full[40], zero pad
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data       // capacity
);
	import ili_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic [WORD_W-1:0] read_value;
	logic [CNT_W-1:0]  length;
	logic              is_empty;
	logic              is_full;

	assign cfg_ready = 1'b1;

	ili_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ili_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (s_axis_tuser),
		.position   (s_axis_tdata[5:0]),
		.value      (s_axis_tdata[37:6]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.read_value (read_value),
		.status     (m_axis_tuser),
		.length     (length),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	assign m_axis_tdata = {7'b0, is_full, is_empty, length, read_value};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the indexed list block: drives requests on s_axis,
// predicts every result and compares it on m_axis. Depends on ili_pkg and the top level.
module tb_top;
	import ili_pkg::*;

	localparam int          LIST_DEPTH = 64;
	localparam logic [31:0] BAD_READ   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [ST_W-1:0]   status;
		logic [CNT_W-1:0]  length;
		logic              is_empty;
		logic              is_full;
	} list_result_t;

	// Keeps a shadow copy of the list and the queue of results still owed.
	class list_scoreboard;
		logic [WORD_W-1:0] words [LIST_DEPTH];
		int unsigned       held;
		logic [CNT_W-1:0]  capacity;
		list_result_t      pending [$];
		int                errors;

		function new();
			held = 0;
			capacity = CAP_RESET;
			errors = 0;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] cap);
			capacity = cap;
		endfunction

		function bit at_limit();
			return held >= ((capacity < LIST_DEPTH) ? int'(capacity) : LIST_DEPTH);
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
				logic [WORD_W-1:0] word);
			list_result_t res;
			int           i;
			res.read_value = '0;
			res.status = ST_DONE;
			case (kind)
				REQ_APPEND: begin
					if (at_limit() || held >= LIST_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						words[held] = word;
						held++;
					end
				end
				REQ_INSERT: begin
					if (pos > held) begin
						res.status = ST_BADPOS;
					end else if (at_limit() || held >= LIST_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						for (i = int'(held); i > int'(pos); i--)
							words[i] = words[i-1];
						words[pos] = word;
						held++;
					end
				end
				REQ_READ: begin
					if (pos >= held) begin
						res.status = ST_BADPOS;
						res.read_value = BAD_READ;
					end else begin
						res.read_value = words[pos];
					end
				end
				REQ_DELETE: begin
					if (pos >= held) begin
						res.status = ST_BADPOS;
					end else begin
						for (i = int'(pos); i + 1 < int'(held); i++)
							words[i] = words[i+1];
						held--;
					end
				end
				REQ_WRITE: begin
					if (pos >= held)
						res.status = ST_BADPOS;
					else
						words[pos] = word;
				end
				default: begin
				end
			endcase
			res.length = held[CNT_W-1:0];
			res.is_empty = (held == 0);
			res.is_full = at_limit();
			pending.push_back(res);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(list_result_t got);
			list_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with no request outstanding", got[40:9], 32'd0);
				return;
			end
			want = pending.pop_front();
			if (got.read_value !== want.read_value)
				report_mismatch("read_value", got.read_value, want.read_value);
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.length !== want.length)
				report_mismatch("length", 32'(got.length), 32'(want.length));
			if (got.is_empty !== want.is_empty)
				report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
			if (got.is_full !== want.is_full)
				report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // position[5:0], value[37:6], zero pad
	logic [2:0]  s_axis_tuser;   // req_type[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // read_value[31:0], length[38:32], is_empty[39],
	                             // is_full[40], zero pad
	logic [1:0]  m_axis_tuser;   // status[1:0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;       // capacity

	list_scoreboard sb = new();
	int             burst_left = 0;

	indexed_list_insert_delete #(
		.DEPTH(LIST_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result monitor.
	always @(posedge clk) begin
		list_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.read_value = m_axis_tdata[31:0];
			got.length = m_axis_tdata[38:32];
			got.is_empty = m_axis_tdata[39];
			got.is_full = m_axis_tdata[40];
			got.status = m_axis_tuser;
			sb.check_result(got);
		end
	end

	// Receiver: alternating ready and stall runs, with occasional long ready stretches.
	initial begin
		bit ready_now;
		int run_left;
		ready_now = 1'b0;
		run_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				ready_now = !ready_now;
				if (ready_now)
					run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 100)
						: $urandom_range(1, 8);
				else
					run_left = $urandom_range(1, 6);
			end
			m_axis_tready <= ready_now;
			run_left--;
		end
	end

	task send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, word, pos};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(kind, pos, word);
		burst_left--;
	endtask

	// Stops sending and waits for every outstanding result.
	task drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_capacity(logic [CNT_W-1:0] cap);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_capacity(cap);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// grow is the percentage of requests that append or insert.
	task run_random(int count, int grow);
		int                r;
		int                hi;
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < grow) begin
				kind = ($urandom_range(0, 2) == 0) ? REQ_INSERT : REQ_APPEND;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 35)
					kind = REQ_READ;
				else if (r < 60)
					kind = REQ_WRITE;
				else if (r < 93)
					kind = REQ_DELETE;
				else
					kind = KIND_W'($urandom_range(5, 7));
			end
			hi = (kind == REQ_INSERT) ? int'(sb.held) : int'(sb.held) - 1;
			if (hi >= 0 && $urandom_range(0, 9) < 8)
				pos = POS_W'($urandom_range(0, hi));
			else
				pos = POS_W'($urandom_range(0, 63));
			word = $urandom;
			if ($urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 3))
					0: word = 32'h8000_0000;
					1: word = 32'h7FFF_FFFF;
					2: word = 32'h0000_0000;
					default: word = 32'hFFFF_FFFF;
				endcase
			end
			send_request(kind, pos, word);
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	initial begin
		int caps [8];
		int grows [8];
		int ph;
		caps = '{64, 127, 1, 40, 64, 6, 2, 64};
		grows = '{60, 50, 50, 45, 85, 20, 40, 50};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// Starts from an empty list at reset capacity, with valid and invalid positions.
		send_request(REQ_READ, 6'd0, 32'd0);
		send_request(REQ_DELETE, 6'd0, 32'd0);
		send_request(REQ_WRITE, 6'd63, 32'h1234_5678);
		send_request(REQ_INSERT, 6'd1, 32'd7);
		send_request(REQ_INSERT, 6'd0, 32'h8000_0000);
		send_request(REQ_APPEND, 6'd63, 32'h7FFF_FFFF);
		send_request(REQ_APPEND, 6'd0, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 6'd1, 32'd0);
		send_request(REQ_INSERT, 6'd4, 32'd12345);
		send_request(REQ_READ, 6'd63, 32'd0);
		send_request(REQ_WRITE, 6'd2, 32'h5555_5555);
		send_request(REQ_READ, 6'd2, 32'hAAAA_AAAA);
		send_request(REQ_DELETE, 6'd0, 32'd0);
		send_request(REQ_DELETE, 6'd3, 32'd0);
		send_request(3'd5, 6'd63, 32'hFFFF_FFFF);
		send_request(3'd6, 6'd0, 32'd1);
		send_request(3'd7, 6'd21, 32'h8000_0000);
		drain();

		// Capacity lowered below the count: entries stay, growth is refused.
		write_capacity(7'd2);
		send_request(REQ_APPEND, 6'd0, 32'd9);
		send_request(REQ_INSERT, 6'd10, 32'd9);
		send_request(REQ_INSERT, 6'd0, 32'd9);
		send_request(REQ_DELETE, 6'd1, 32'd0);
		send_request(REQ_APPEND, 6'd0, 32'd11);
		drain();

		// Zero capacity counts as always full.
		write_capacity(7'd0);
		send_request(REQ_APPEND, 6'd0, 32'd1);
		send_request(REQ_INSERT, 6'd0, 32'd1);
		drain();

		for (ph = 0; ph < 8; ph++) begin
			write_capacity(CNT_W'(caps[ph]));
			run_random(68, grows[ph]);
			drain();
		end

		repeat (80) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report_mismatch("results never returned", 32'(sb.pending.size()), 32'd0);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
